@@ rtl/mbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbc_pkg: shared definitions for the maze backtracker carver
// Field widths, register indexes, action and move codes, the move order
// table and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mbc_pkg;

   localparam int MBC_MAX_ROWS    = 64;
   localparam int MBC_MAX_COLS    = 64;
   localparam int MBC_STACK_DEPTH = 1024;

   localparam int COORD_W   = 6;
   localparam int ORDER_W   = 5;
   localparam int DEPTH_W   = 11;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;
   // bound arithmetic: holds a config limit of up to 127 plus a two-cell move and the margin row
   localparam int CALC_W    = 10;

   localparam logic [CFG_W-1:0] MAZE_ROWS_RST = 7'd64;
   localparam logic [CFG_W-1:0] MAZE_COLS_RST = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_COLS = 2'd1;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic [ORDER_W-1:0] ORDER_MAX = 5'd23;
   localparam int PERM_COUNT = 24;

   typedef enum logic [1:0] {
      ACT_STARTED     = 2'd0,
      ACT_CARVED      = 2'd1,
      ACT_BACKTRACKED = 2'd2,
      ACT_DONE        = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   // all orderings of the four moves, lexicographic
   localparam dir_type PERM_TABLE [PERM_COUNT][4] = '{
      '{DIR_RIGHT, DIR_LEFT,  DIR_DOWN,  DIR_UP   },
      '{DIR_RIGHT, DIR_LEFT,  DIR_UP,    DIR_DOWN },
      '{DIR_RIGHT, DIR_DOWN,  DIR_LEFT,  DIR_UP   },
      '{DIR_RIGHT, DIR_DOWN,  DIR_UP,    DIR_LEFT },
      '{DIR_RIGHT, DIR_UP,    DIR_LEFT,  DIR_DOWN },
      '{DIR_RIGHT, DIR_UP,    DIR_DOWN,  DIR_LEFT },
      '{DIR_LEFT,  DIR_RIGHT, DIR_DOWN,  DIR_UP   },
      '{DIR_LEFT,  DIR_RIGHT, DIR_UP,    DIR_DOWN },
      '{DIR_LEFT,  DIR_DOWN,  DIR_RIGHT, DIR_UP   },
      '{DIR_LEFT,  DIR_DOWN,  DIR_UP,    DIR_RIGHT},
      '{DIR_LEFT,  DIR_UP,    DIR_RIGHT, DIR_DOWN },
      '{DIR_LEFT,  DIR_UP,    DIR_DOWN,  DIR_RIGHT},
      '{DIR_DOWN,  DIR_RIGHT, DIR_LEFT,  DIR_UP   },
      '{DIR_DOWN,  DIR_RIGHT, DIR_UP,    DIR_LEFT },
      '{DIR_DOWN,  DIR_LEFT,  DIR_RIGHT, DIR_UP   },
      '{DIR_DOWN,  DIR_LEFT,  DIR_UP,    DIR_RIGHT},
      '{DIR_DOWN,  DIR_UP,    DIR_RIGHT, DIR_LEFT },
      '{DIR_DOWN,  DIR_UP,    DIR_LEFT,  DIR_RIGHT},
      '{DIR_UP,    DIR_RIGHT, DIR_LEFT,  DIR_DOWN },
      '{DIR_UP,    DIR_RIGHT, DIR_DOWN,  DIR_LEFT },
      '{DIR_UP,    DIR_LEFT,  DIR_RIGHT, DIR_DOWN },
      '{DIR_UP,    DIR_LEFT,  DIR_DOWN,  DIR_RIGHT},
      '{DIR_UP,    DIR_DOWN,  DIR_RIGHT, DIR_LEFT },
      '{DIR_UP,    DIR_DOWN,  DIR_LEFT,  DIR_RIGHT}
   };

   typedef struct packed {
      logic accept;       // latch request fields, reset counters
      logic stk_read;     // read top of stack
      logic clr_step;     // write one wall during the grid sweep
      logic open;         // open start cell and seed the stack
      logic probe_issue;  // latch target and read its wall bit
      logic k_next;       // move on to the next move in the order
      logic carve_tgt;    // open target, push it
      logic carve_mid;    // open the cell between
      logic pop;          // no move taken, drop the top
      logic set_done;     // step on an empty stack
      logic emit;         // load the result into the output register
   } mbc_cmd_type;

   typedef struct packed {
      logic req_step;
      logic sp_zero;
      logic stack_full;
      logic clr_last;
      logic probe_ok;
      logic wall_set;
      logic k_last;
      logic out_free;
   } mbc_status_type;

endpackage

@@ rtl/mbc_if.sv @@
// ----------------------------------------------------------------------------
// mbc_if: channel interfaces of the maze backtracker carver
// Request, result and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface mbc_req_if;
   import mbc_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [COORD_W-1:0] start_row;
   logic [COORD_W-1:0] start_col;
   logic [ORDER_W-1:0] order_index;

   modport source (output valid, req_type, start_row, start_col, order_index, input ready);
   modport sink   (input valid, req_type, start_row, start_col, order_index, output ready);
endinterface

interface mbc_rsp_if;
   import mbc_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [COORD_W-1:0] cell_row;
   logic [COORD_W-1:0] cell_col;
   logic [COORD_W-1:0] between_row;
   logic [COORD_W-1:0] between_col;
   logic [DEPTH_W-1:0] stack_depth;

   modport source (output valid, action, cell_row, cell_col, between_row, between_col,
                   stack_depth, input ready);
   modport sink   (input valid, action, cell_row, cell_col, between_row, between_col,
                   stack_depth, output ready);
endinterface

interface mbc_csr_if;
   import mbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/maze_backtracker_carver_unit.sv @@
// Start item: accept, wall sweep over every cell, open of the start cell, result.
// Step item: straight to the result on an empty or full stack, else probe the moves
// in order, a wall check after each in-bounds probe, to a carve at the first walled
// target or a backtrack after all four; the one-port wall map reads one neighbour per probe/check pair.
// Reset is synchronous and clears control and config; no clearing pass follows,
// the wall map is swept on every start item.
// ----------------------------------------------------------------------------
// maze_backtracker_carver_unit: recursive backtracker maze carver
// Sequencer plus datapath holding the wall map and the path stack.
// ----------------------------------------------------------------------------
module maze_backtracker_carver_unit #(
   parameter int MAX_ROWS    = mbc_pkg::MBC_MAX_ROWS,
   parameter int MAX_COLS    = mbc_pkg::MBC_MAX_COLS,
   parameter int STACK_DEPTH = mbc_pkg::MBC_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mbc_req_if.sink    req_ch,
   mbc_rsp_if.source  rsp_ch,
   mbc_csr_if.sink    csr_ch
);
   import mbc_pkg::*;

   // Command/status pair is the only link between sequencer and datapath.
   mbc_cmd_type    cmd;
   mbc_status_type status;
   logic           req_ready;

   // A request beat is taken only in idle; the finished result sits in the
   // output register, so the next beat can be taken while it waits.
   assign req_ch.ready = req_ready;

   // Sequencer: start sweeps every cell to wall, then opens the start cell;
   // step probes neighbours in permutation order, one wall read per in-bounds move tried.
   mbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: wall map (one bit per cell, row-major on MAX_COLS), path stack,
   // bound checks against the current grid size, result register.
   mbc_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_ch.req_type),
      .start_row   (req_ch.start_row),
      .start_col   (req_ch.start_col),
      .order_index (req_ch.order_index),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

@@ rtl/mbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbc_ctrl: sequencer of the maze backtracker carver
// One-hot state machine: grid sweep on start, neighbour probing on step.
// ----------------------------------------------------------------------------
module mbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mbc_pkg::mbc_status_type status,
   output mbc_pkg::mbc_cmd_type    cmd
);
   import mbc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CLEAR     = 8'b0000_0010,
      ST_OPEN      = 8'b0000_0100,
      ST_PROBE     = 8'b0000_1000,
      ST_CHECK     = 8'b0001_0000,
      ST_CARVE_TGT = 8'b0010_0000,
      ST_CARVE_MID = 8'b0100_0000,
      ST_RESULT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!status.req_step) begin
                  state_in = ST_CLEAR;
               end else if (status.sp_zero) begin
                  cmd.set_done = 1'b1;
                  state_in     = ST_RESULT;
               end else if (status.stack_full) begin
                  cmd.pop  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  cmd.stk_read = 1'b1;
                  state_in     = ST_PROBE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            cmd.open = 1'b1;
            state_in = ST_RESULT;
         end
         ST_PROBE: begin
            if (status.probe_ok) begin
               cmd.probe_issue = 1'b1;
               state_in        = ST_CHECK;
            end else if (status.k_last) begin
               cmd.pop  = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.k_next = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.wall_set) begin
               state_in = ST_CARVE_TGT;
            end else if (status.k_last) begin
               cmd.pop  = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.k_next = 1'b1;
               state_in   = ST_PROBE;
            end
         end
         ST_CARVE_TGT: begin
            cmd.carve_tgt = 1'b1;
            state_in      = ST_CARVE_MID;
         end
         ST_CARVE_MID: begin
            cmd.carve_mid = 1'b1;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/mbc_datapath.sv @@
// ----------------------------------------------------------------------------
// mbc_datapath: grid, stack and result path of the maze backtracker carver
// Wall map and path stack memories, bound checks, config and output register.
// ----------------------------------------------------------------------------
module mbc_datapath #(
   parameter int MAX_ROWS    = mbc_pkg::MBC_MAX_ROWS,
   parameter int MAX_COLS    = mbc_pkg::MBC_MAX_COLS,
   parameter int STACK_DEPTH = mbc_pkg::MBC_STACK_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_type,
   input  logic [mbc_pkg::COORD_W-1:0] start_row,
   input  logic [mbc_pkg::COORD_W-1:0] start_col,
   input  logic [mbc_pkg::ORDER_W-1:0] order_index,
   mbc_rsp_if.source                   rsp_ch,
   mbc_csr_if.sink                     csr_ch,
   input  mbc_pkg::mbc_cmd_type         cmd,
   output mbc_pkg::mbc_status_type      status
);
   import mbc_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int SIW   = $clog2(STACK_DEPTH);
   localparam int SPW   = $clog2(STACK_DEPTH + 1);

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_COLS) + AW'(c);
   endfunction

   // config
   logic [CFG_W-1:0] maze_rows_ff, maze_cols_ff;
   logic [CALC_W-1:0] rows_eff, cols_eff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         maze_rows_ff <= MAZE_ROWS_RST;
         maze_cols_ff <= MAZE_COLS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MAZE_ROWS: maze_rows_ff <= csr_ch.wdata;
            CSR_MAZE_COLS: maze_cols_ff <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   assign rows_eff = (CALC_W'(maze_rows_ff) > CALC_W'(MAX_ROWS)) ? CALC_W'(MAX_ROWS)
                                                                 : CALC_W'(maze_rows_ff);
   assign cols_eff = (CALC_W'(maze_cols_ff) > CALC_W'(MAX_COLS)) ? CALC_W'(MAX_COLS)
                                                                 : CALC_W'(maze_cols_ff);

   // request latch and counters
   logic [COORD_W-1:0] start_row_ff, start_col_ff;
   logic [ORDER_W-1:0] order_ff;
   logic [1:0]         k_ff;
   logic [AW-1:0]      clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         clr_addr_ff <= '0;
      end else if (cmd.accept) begin
         k_ff        <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.k_next)   k_ff        <= k_ff + 2'd1;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         start_row_ff <= start_row;
         start_col_ff <= start_col;
         order_ff     <= (order_index > ORDER_MAX) ? ORDER_MAX : order_index;
      end
   end

   logic          start_ok;
   logic [RW-1:0] start_r;
   logic [CW-1:0] start_c;

   assign start_ok = (CALC_W'(start_row_ff) < rows_eff) && (CALC_W'(start_col_ff) < cols_eff);
   assign start_r  = RW'(start_row_ff);
   assign start_c  = CW'(start_col_ff);

   // stack
   logic [SPW-1:0]       sp_ff;
   logic [RW+CW-1:0]     stack_mem [STACK_DEPTH];
   logic [RW+CW-1:0]     stack_rd_ff;
   logic                 stk_we;
   logic [SIW-1:0]       stk_waddr;
   logic [RW+CW-1:0]     stk_wdata;
   logic [RW-1:0]        tgt_row_ff, mid_row_ff;
   logic [CW-1:0]        tgt_col_ff, mid_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (cmd.open) begin
         sp_ff <= start_ok ? SPW'(1) : '0;
      end else if (cmd.carve_tgt) begin
         sp_ff <= sp_ff + SPW'(1);
      end else if (cmd.pop) begin
         sp_ff <= sp_ff - SPW'(1);
      end
   end

   assign stk_we    = (cmd.open && start_ok) || cmd.carve_tgt;
   assign stk_waddr = cmd.open ? '0 : SIW'(sp_ff);
   assign stk_wdata = cmd.open ? {start_r, start_c} : {tgt_row_ff, tgt_col_ff};

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.stk_read) begin
         stack_rd_ff <= stack_mem[SIW'(sp_ff - SPW'(1))];
      end
   end

   // neighbour bounds
   dir_type           dir;
   logic [CALC_W-1:0] row_e, col_e, nr, nc, mr, mc;
   logic              under;
   logic              probe_ok;

   assign dir   = PERM_TABLE[order_ff][k_ff];
   assign row_e = CALC_W'(stack_rd_ff[RW+CW-1:CW]);
   assign col_e = CALC_W'(stack_rd_ff[CW-1:0]);

   always_comb begin
      nr    = row_e;
      nc    = col_e;
      mr    = row_e;
      mc    = col_e;
      under = 1'b0;
      unique case (dir)
         DIR_RIGHT: begin
            nc = col_e + CALC_W'(2);
            mc = col_e + CALC_W'(1);
         end
         DIR_LEFT: begin
            under = (col_e < CALC_W'(2));
            nc    = col_e - CALC_W'(2);
            mc    = col_e - CALC_W'(1);
         end
         DIR_DOWN: begin
            nr = row_e + CALC_W'(2);
            mr = row_e + CALC_W'(1);
         end
         DIR_UP: begin
            under = (row_e < CALC_W'(2));
            nr    = row_e - CALC_W'(2);
            mr    = row_e - CALC_W'(1);
         end
         default: ;
      endcase
   end

   // target must sit above the last row of the current grid
   assign probe_ok = !under && ((nr + CALC_W'(1)) < rows_eff) && (nc < cols_eff);

   always_ff @(posedge clock) begin
      if (cmd.probe_issue) begin
         tgt_row_ff <= RW'(nr);
         tgt_col_ff <= CW'(nc);
         mid_row_ff <= RW'(mr);
         mid_col_ff <= CW'(mc);
      end
   end

   // wall map
   logic          wall_mem [CELLS];
   logic          wall_rd_ff;
   logic          wall_we;
   logic [AW-1:0] wall_waddr;
   logic          wall_wdata;

   always_comb begin
      wall_we    = 1'b0;
      wall_waddr = clr_addr_ff;
      wall_wdata = 1'b0;
      if (cmd.clr_step) begin
         wall_we    = 1'b1;
         wall_wdata = 1'b1;
      end else if (cmd.open) begin
         wall_we    = start_ok;
         wall_waddr = cell_addr(start_r, start_c);
      end else if (cmd.carve_tgt) begin
         wall_we    = 1'b1;
         wall_waddr = cell_addr(tgt_row_ff, tgt_col_ff);
      end else if (cmd.carve_mid) begin
         wall_we    = 1'b1;
         wall_waddr = cell_addr(mid_row_ff, mid_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[wall_waddr] <= wall_wdata;
      end
      if (cmd.probe_issue) begin
         wall_rd_ff <= wall_mem[cell_addr(RW'(nr), CW'(nc))];
      end
   end

   // pending result
   action_type         pend_action_ff;
   logic [COORD_W-1:0] pend_cell_row_ff, pend_cell_col_ff;
   logic [COORD_W-1:0] pend_btw_row_ff, pend_btw_col_ff;

   always_ff @(posedge clock) begin
      if (cmd.open) begin
         pend_action_ff   <= ACT_STARTED;
         pend_cell_row_ff <= start_row_ff;
         pend_cell_col_ff <= start_col_ff;
         pend_btw_row_ff  <= '0;
         pend_btw_col_ff  <= '0;
      end else if (cmd.carve_mid) begin
         pend_action_ff   <= ACT_CARVED;
         pend_cell_row_ff <= COORD_W'(tgt_row_ff);
         pend_cell_col_ff <= COORD_W'(tgt_col_ff);
         pend_btw_row_ff  <= COORD_W'(mid_row_ff);
         pend_btw_col_ff  <= COORD_W'(mid_col_ff);
      end else if (cmd.pop || cmd.set_done) begin
         pend_action_ff   <= cmd.pop ? ACT_BACKTRACKED : ACT_DONE;
         pend_cell_row_ff <= '0;
         pend_cell_col_ff <= '0;
         pend_btw_row_ff  <= '0;
         pend_btw_col_ff  <= '0;
      end
   end

   // output register
   logic               rsp_valid_ff;
   action_type         rsp_action_ff;
   logic [COORD_W-1:0] rsp_cell_row_ff, rsp_cell_col_ff, rsp_btw_row_ff, rsp_btw_col_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_action_ff   <= pend_action_ff;
         rsp_cell_row_ff <= pend_cell_row_ff;
         rsp_cell_col_ff <= pend_cell_col_ff;
         rsp_btw_row_ff  <= pend_btw_row_ff;
         rsp_btw_col_ff  <= pend_btw_col_ff;
         rsp_depth_ff    <= DEPTH_W'(sp_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = rsp_action_ff;
   assign rsp_ch.cell_row    = rsp_cell_row_ff;
   assign rsp_ch.cell_col    = rsp_cell_col_ff;
   assign rsp_ch.between_row = rsp_btw_row_ff;
   assign rsp_ch.between_col = rsp_btw_col_ff;
   assign rsp_ch.stack_depth = rsp_depth_ff;

   // status to the sequencer
   assign status.req_step   = (req_type == REQ_STEP);
   assign status.sp_zero    = (sp_ff == '0);
   assign status.stack_full = (sp_ff == SPW'(STACK_DEPTH));
   assign status.clr_last   = (clr_addr_ff == AW'(CELLS - 1));
   assign status.probe_ok   = probe_ok;
   assign status.wall_set   = wall_rd_ff;
   assign status.k_last     = &k_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ch.ready;

endmodule

@@ rtl/mbc_checker.sv @@
// ----------------------------------------------------------------------------
// mbc_checker: port-level checks of the maze backtracker carver
// Result handshake and field rules per action, bound to the top level.
// ----------------------------------------------------------------------------
module mbc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  action,
   input logic [mbc_pkg::COORD_W-1:0] cell_row,
   input logic [mbc_pkg::COORD_W-1:0] cell_col,
   input logic [mbc_pkg::COORD_W-1:0] between_row,
   input logic [mbc_pkg::COORD_W-1:0] between_col,
   input logic [mbc_pkg::DEPTH_W-1:0] stack_depth
);
   import mbc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({action, cell_row, cell_col,
                                           between_row, between_col, stack_depth}))
      else $error("result beat changed while stalled");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (action == ACT_DONE) |-> (stack_depth == '0) && (cell_row == '0) &&
         (cell_col == '0) && (between_row == '0) && (between_col == '0))
      else $error("done beat with non-empty stack or coordinates");

   a_start_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (action == ACT_STARTED) |-> (stack_depth <= DEPTH_W'(1)) &&
         (between_row == '0) && (between_col == '0))
      else $error("start beat with bad depth or wall cell");

   a_back_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (action == ACT_BACKTRACKED) |-> (cell_row == '0) && (cell_col == '0) &&
         (between_row == '0) && (between_col == '0))
      else $error("backtrack beat with coordinates");

endmodule

bind maze_backtracker_carver_unit mbc_checker u_mbc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .action      (rsp_ch.action),
   .cell_row    (rsp_ch.cell_row),
   .cell_col    (rsp_ch.cell_col),
   .between_row (rsp_ch.between_row),
   .between_col (rsp_ch.between_col),
   .stack_depth (rsp_ch.stack_depth)
);
